// ===== hdl/uirf_pkg.sv =====
// Shared types and constants of the UDP/IPv4 receive filter.
package uirf_pkg;

   localparam int OFF_W   = 11;
   localparam int COUNT_W = 11;

   localparam logic [OFF_W-1:0]   MAX_FRAME   = 11'd1514;
   localparam logic [COUNT_W-1:0] MAX_PAYLOAD = 11'd1024;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [15:0] UDP_HDR    = 16'd8;

   localparam logic [OFF_W-1:0] OFF_ETYPE   = 11'd12;
   localparam logic [OFF_W-1:0] OFF_PROTO   = 11'd23;
   localparam logic [OFF_W-1:0] OFF_SRC_IP  = 11'd26;
   localparam logic [OFF_W-1:0] OFF_DST_IP  = 11'd30;
   localparam logic [OFF_W-1:0] OFF_SPORT   = 11'd34;
   localparam logic [OFF_W-1:0] OFF_DPORT   = 11'd36;
   localparam logic [OFF_W-1:0] OFF_ULEN    = 11'd38;
   localparam logic [OFF_W-1:0] PAYLOAD_OFF = 11'd42;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;
   localparam int QUEUE_CW    = 4;
   localparam logic [QUEUE_CW-1:0] QUEUE_ROOM = 4'd4;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_SHORT     = 4'd1,
      ST_ETHERTYPE = 4'd2,
      ST_PROTO     = 4'd3,
      ST_SRCIP     = 4'd4,
      ST_DSTIP     = 4'd5,
      ST_SPORT     = 4'd6,
      ST_DPORT     = 4'd7,
      ST_UDPLEN    = 4'd8
   } uirf_status_type;

   typedef enum logic [2:0] {
      REG_LOCAL_IP    = 3'd0,
      REG_SERVER_IP   = 3'd1,
      REG_SERVER_PORT = 3'd2,
      REG_LOCAL_PORT  = 3'd3,
      REG_MAX_PAYLOAD = 3'd4
   } uirf_reg_type;

   typedef struct packed {
      logic                kind;
      logic                last;
      logic [7:0]          payload_byte;
      uirf_status_type     status;
      logic [COUNT_W-1:0]  payload_count;
   } uirf_result_type;

   typedef struct packed {
      logic            first_vld;
      logic            second_vld;
      uirf_result_type first;
      uirf_result_type second;
   } uirf_push_type;

endpackage

// ===== hdl/udp_ipv4_receive_filter_top.sv =====
// Top level of the UDP/IPv4 receive filter.
//
// Frame bytes enter on req_ one word per byte, req_tlast on the final byte.
// The block checks Ethernet, IPv4 and UDP headers against the csr_ registers
// and forwards UDP payload bytes on rsp_ (rsp_tuser low), then one status
// word per frame (rsp_tuser and rsp_tlast high) with the first failing check
// and the payload byte count.
// An accepted byte is registered, checked from the input register and then
// written into the result queue, from which its word is handed out.
// Throughput: one byte per cycle; a frame's final byte can yield two words,
// drained one per cycle through an eight-word result queue.
// Back-pressure: req_tready drops while more than four words wait in the
// queue, so a stalled receiver stops the input without loss.
// Reset clears the frame state and the queue and loads register defaults
// (local port 49152, payload limit 1024). csr_ is always ready; write it
// only while no frame is in progress.
module udp_ipv4_receive_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] payload_byte, [11:8] status,
                                     // [22:12] payload_count, [23] zero
   output logic        rsp_tuser,    // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import uirf_pkg::*;

   uirf_push_type   push;
   uirf_result_type word;
   logic            room;

   assign req_tready = room;
   assign csr_ready  = 1'b1;

   uirf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_tvalid && req_tready),
      .in_data   (req_tdata),
      .in_last   (req_tlast),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push)
   );

   uirf_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (word)
   );

   assign rsp_tdata = {1'b0, word.payload_count, word.status, word.payload_byte};
   assign rsp_tuser = word.kind;
   assign rsp_tlast = word.last;

endmodule

// ===== hdl/uirf_parser.sv =====
// Header checker and payload gate: input register, frame state and config registers.
module uirf_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  logic [7:0]             in_data,
   input  logic                   in_last,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   output uirf_pkg::uirf_push_type push
);
   import uirf_pkg::*;

   logic                  in_vld_ff;
   logic [7:0]            in_data_ff;
   logic                  in_last_ff;

   logic [31:0]           local_ip_ff;
   logic [31:0]           server_ip_ff;
   logic [15:0]           server_port_ff;
   logic [15:0]           local_port_ff;
   logic [COUNT_W-1:0]    max_payload_ff;

   logic [OFF_W-1:0]      offset_ff, offset_in;
   uirf_status_type       fail_ff, fail_in;
   logic [15:0]           ulen_ff, ulen_in;
   logic [COUNT_W-1:0]    emitted_ff, emitted_in;

   logic                  active;
   logic                  bad;
   uirf_status_type       code;
   logic [15:0]           avail;
   logic [COUNT_W-1:0]    lim_cfg;
   logic                  emit;
   logic                  done;
   uirf_status_type       end_status;
   uirf_result_type       pay_res;
   uirf_result_type       stat_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_accept;
      end
      if (in_accept) begin
         in_data_ff <= in_data;
         in_last_ff <= in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff    <= 32'd0;
         server_ip_ff   <= 32'd0;
         server_port_ff <= 16'd0;
         local_port_ff  <= 16'd49152;
         max_payload_ff <= MAX_PAYLOAD;
      end else if (csr_write) begin
         unique case (uirf_reg_type'(csr_index))
            REG_LOCAL_IP:    local_ip_ff    <= csr_data;
            REG_SERVER_IP:   server_ip_ff   <= csr_data;
            REG_SERVER_PORT: server_port_ff <= csr_data[15:0];
            REG_LOCAL_PORT:  local_port_ff  <= csr_data[15:0];
            REG_MAX_PAYLOAD: max_payload_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      active = offset_ff < MAX_FRAME;
      bad    = 1'b0;
      code   = ST_OK;
      ulen_in = ulen_ff;
      if (active) begin
         unique case (offset_ff)
            OFF_ETYPE: begin
               bad = in_data_ff != ETYPE_IPV4[15:8]; code = ST_ETHERTYPE;
            end
            OFF_ETYPE + 11'd1: begin
               bad = in_data_ff != ETYPE_IPV4[7:0]; code = ST_ETHERTYPE;
            end
            OFF_PROTO: begin
               bad = in_data_ff != PROTO_UDP; code = ST_PROTO;
            end
            OFF_SRC_IP: begin
               bad = in_data_ff != server_ip_ff[31:24]; code = ST_SRCIP;
            end
            OFF_SRC_IP + 11'd1: begin
               bad = in_data_ff != server_ip_ff[23:16]; code = ST_SRCIP;
            end
            OFF_SRC_IP + 11'd2: begin
               bad = in_data_ff != server_ip_ff[15:8]; code = ST_SRCIP;
            end
            OFF_SRC_IP + 11'd3: begin
               bad = in_data_ff != server_ip_ff[7:0]; code = ST_SRCIP;
            end
            OFF_DST_IP: begin
               bad = in_data_ff != local_ip_ff[31:24]; code = ST_DSTIP;
            end
            OFF_DST_IP + 11'd1: begin
               bad = in_data_ff != local_ip_ff[23:16]; code = ST_DSTIP;
            end
            OFF_DST_IP + 11'd2: begin
               bad = in_data_ff != local_ip_ff[15:8]; code = ST_DSTIP;
            end
            OFF_DST_IP + 11'd3: begin
               bad = in_data_ff != local_ip_ff[7:0]; code = ST_DSTIP;
            end
            OFF_SPORT: begin
               bad = in_data_ff != server_port_ff[15:8]; code = ST_SPORT;
            end
            OFF_SPORT + 11'd1: begin
               bad = in_data_ff != server_port_ff[7:0]; code = ST_SPORT;
            end
            OFF_DPORT: begin
               bad = in_data_ff != local_port_ff[15:8]; code = ST_DPORT;
            end
            OFF_DPORT + 11'd1: begin
               bad = in_data_ff != local_port_ff[7:0]; code = ST_DPORT;
            end
            OFF_ULEN: begin
               ulen_in = {in_data_ff, 8'h00};
            end
            OFF_ULEN + 11'd1: begin
               ulen_in = {ulen_ff[15:8], in_data_ff};
               bad     = {ulen_ff[15:8], in_data_ff} < UDP_HDR;
               code    = ST_UDPLEN;
            end
            default: ;
         endcase
      end
      fail_in = (fail_ff == ST_OK && bad) ? code : fail_ff;
   end

   always_comb begin
      avail   = ulen_in - UDP_HDR;
      lim_cfg = (max_payload_ff > MAX_PAYLOAD) ? MAX_PAYLOAD : max_payload_ff;
      emit    = in_vld_ff && active && offset_ff >= PAYLOAD_OFF && fail_in == ST_OK
                && emitted_ff < lim_cfg && {5'd0, emitted_ff} < avail;
      emitted_in = emit ? emitted_ff + 11'd1 : emitted_ff;
      offset_in  = active ? offset_ff + 11'd1 : offset_ff;
      done       = in_vld_ff && in_last_ff;
      end_status = (offset_in < PAYLOAD_OFF) ? ST_SHORT : fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         fail_ff    <= ST_OK;
         ulen_ff    <= 16'd0;
         emitted_ff <= '0;
      end else if (in_vld_ff) begin
         if (done) begin
            offset_ff  <= '0;
            fail_ff    <= ST_OK;
            ulen_ff    <= 16'd0;
            emitted_ff <= '0;
         end else begin
            offset_ff  <= offset_in;
            fail_ff    <= fail_in;
            ulen_ff    <= ulen_in;
            emitted_ff <= emitted_in;
         end
      end
   end

   always_comb begin
      pay_res.kind          = 1'b0;
      pay_res.last          = 1'b0;
      pay_res.payload_byte  = in_data_ff;
      pay_res.status        = ST_OK;
      pay_res.payload_count = '0;
      stat_res.kind          = 1'b1;
      stat_res.last          = 1'b1;
      stat_res.payload_byte  = 8'd0;
      stat_res.status        = end_status;
      stat_res.payload_count = emitted_in;
      push.first_vld  = emit || done;
      push.second_vld = emit && done;
      push.first      = emit ? pay_res : stat_res;
      push.second     = stat_res;
   end

endmodule

// ===== hdl/uirf_out_queue.sv =====
// Result queue: takes up to two words per cycle, hands out one per cycle.
module uirf_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  uirf_pkg::uirf_push_type  push,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output uirf_pkg::uirf_result_type out_word
);
   import uirf_pkg::*;

   uirf_result_type        entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ff, wr_in;
   logic [QUEUE_AW-1:0]    rd_ff, rd_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;
   logic [1:0]             n_push;
   logic                   pop;

   always_comb begin
      n_push   = {1'b0, push.first_vld} + {1'b0, push.second_vld};
      pop      = out_valid && out_ready;
      wr_in    = wr_ff + {1'b0, n_push};
      rd_in    = rd_ff + {{(QUEUE_AW-1){1'b0}}, pop};
      count_in = count_ff + {2'd0, n_push} - {3'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_vld) begin
         entries_ff[wr_ff] <= push.first;
      end
      if (push.second_vld) begin
         entries_ff[wr_ff + 3'd1] <= push.second;
      end
   end

   // Leave space for the word in the input register and the one being taken.
   assign room      = count_ff <= QUEUE_ROOM;
   assign out_valid = count_ff != '0;
   assign out_word  = entries_ff[rd_ff];

endmodule

// ===== hdl/uirf_checker.sv =====
// Port-level checks of the UDP/IPv4 receive filter, bound to the top level.
module uirf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("output valid or input stalled after reset");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tlast && rsp_tdata[23:8] == 16'd0)
      else $error("payload word carries status fields");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[7:0] == 8'd0
      && rsp_tdata[22:12] <= 11'd1024 && rsp_tdata[11:8] <= 4'd8)
      else $error("malformed status word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled output word changed");

endmodule

bind udp_ipv4_receive_filter_top uirf_checker u_uirf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/udp_filter_checker.sv =====
// Checker for the UDP/IPv4 receive filter: predicts every output word and compares it.
module udp_filter_checker
   import uirf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          owed,
   output int          errors
);

   logic [31:0]        cfg_local_ip;
   logic [31:0]        cfg_server_ip;
   logic [15:0]        cfg_server_port;
   logic [15:0]        cfg_local_port;
   logic [COUNT_W-1:0] cfg_max_payload;

   logic [OFF_W-1:0]   frame_off;
   uirf_status_type    first_fail;
   logic [15:0]        udp_len;
   logic [COUNT_W-1:0] sent_count;

   uirf_result_type    owed_words[$];

   task automatic clear_frame();
      frame_off  = '0;
      first_fail = ST_OK;
      udp_len    = '0;
      sent_count = '0;
   endtask

   task automatic filter_byte(input logic [7:0] b, input logic fin);
      uirf_status_type    code;
      logic               bad;
      logic [COUNT_W-1:0] cap;
      logic [15:0]        room;
      uirf_result_type    w;
      code = ST_OK;
      bad  = 1'b0;
      if (frame_off < MAX_FRAME) begin
         if (frame_off == OFF_ETYPE) begin
            code = ST_ETHERTYPE;
            bad  = b != ETYPE_IPV4[15:8];
         end else if (frame_off == OFF_ETYPE + 11'd1) begin
            code = ST_ETHERTYPE;
            bad  = b != ETYPE_IPV4[7:0];
         end else if (frame_off == OFF_PROTO) begin
            code = ST_PROTO;
            bad  = b != PROTO_UDP;
         end else if (frame_off >= OFF_SRC_IP && frame_off < OFF_DST_IP) begin
            code = ST_SRCIP;
            bad  = b != 8'(cfg_server_ip >> (8 * int'(OFF_DST_IP - 11'd1 - frame_off)));
         end else if (frame_off >= OFF_DST_IP && frame_off < OFF_SPORT) begin
            code = ST_DSTIP;
            bad  = b != 8'(cfg_local_ip >> (8 * int'(OFF_SPORT - 11'd1 - frame_off)));
         end else if (frame_off == OFF_SPORT) begin
            code = ST_SPORT;
            bad  = b != cfg_server_port[15:8];
         end else if (frame_off == OFF_SPORT + 11'd1) begin
            code = ST_SPORT;
            bad  = b != cfg_server_port[7:0];
         end else if (frame_off == OFF_DPORT) begin
            code = ST_DPORT;
            bad  = b != cfg_local_port[15:8];
         end else if (frame_off == OFF_DPORT + 11'd1) begin
            code = ST_DPORT;
            bad  = b != cfg_local_port[7:0];
         end else if (frame_off == OFF_ULEN) begin
            udp_len = {b, 8'h00};
         end else if (frame_off == OFF_ULEN + 11'd1) begin
            udp_len[7:0] = b;
            code = ST_UDPLEN;
            bad  = udp_len < UDP_HDR;
         end
         if (bad && first_fail == ST_OK)
            first_fail = code;
         if (frame_off >= PAYLOAD_OFF && first_fail == ST_OK) begin
            cap  = (cfg_max_payload > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_max_payload;
            room = udp_len - UDP_HDR;
            if (room < 16'(cap))
               cap = room[COUNT_W-1:0];
            if (sent_count < cap) begin
               sent_count++;
               w = '{kind: 1'b0, last: 1'b0, payload_byte: b, status: ST_OK,
                     payload_count: '0};
               owed_words.push_back(w);
            end
         end
         frame_off++;
      end
      if (fin) begin
         w = '{kind: 1'b1, last: 1'b1, payload_byte: 8'h00,
               status: (frame_off < PAYLOAD_OFF) ? ST_SHORT : first_fail,
               payload_count: sent_count};
         owed_words.push_back(w);
         clear_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      uirf_result_type w;
      if (reset) begin
         cfg_local_ip    = '0;
         cfg_server_ip   = '0;
         cfg_server_port = '0;
         cfg_local_port  = 16'd49152;
         cfg_max_payload = MAX_PAYLOAD;
         clear_frame();
         owed_words.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready)
            case (csr_index)
               REG_LOCAL_IP:    cfg_local_ip    = csr_data;
               REG_SERVER_IP:   cfg_server_ip   = csr_data;
               REG_SERVER_PORT: cfg_server_port = csr_data[15:0];
               REG_LOCAL_PORT:  cfg_local_port  = csr_data[15:0];
               REG_MAX_PAYLOAD: cfg_max_payload = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         if (req_tvalid && req_tready)
            filter_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_words.size() == 0) begin
               $error("unexpected word: tdata %0h, tuser %0b, tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               w = owed_words.pop_front();
               check_field("kind", 32'(w.kind), 32'(rsp_tuser));
               check_field("last", 32'(w.last), 32'(rsp_tlast));
               check_field("payload_byte", 32'(w.payload_byte), 32'(rsp_tdata[7:0]));
               check_field("status", 32'(w.status), 32'(rsp_tdata[11:8]));
               check_field("payload_count", 32'(w.payload_count),
                           32'(rsp_tdata[22:12]));
               check_field("pad", 32'd0, 32'(rsp_tdata[23]));
            end
         end
      end
      owed = owed_words.size();
   end

endmodule

// ===== bench/tb.sv =====
// Stimulus, watchdog and verdict for the UDP/IPv4 receive filter.
module tb;
   import uirf_pkg::*;

   localparam int GAP_PCT       = 11;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 145;
   localparam int SETTINGS_RUN  = 5;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_data   = '0;
   int          owed;
   int          errors;

   logic [31:0] lip, sip;
   logic [15:0] spt, lpt;
   logic [7:0]  frame_bytes[$];
   bit          gaps_on      = 1'b1;
   bit          hold_pending = 1'b0;
   int          hold_left    = 0;
   int          quiet        = 0;

   always #5 clock = ~clock;

   udp_ipv4_receive_filter_top dut (.*);

   udp_filter_checker watcher (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("udp_ipv4_receive_filter_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic put(input int idx, input logic [7:0] v);
      if (idx < frame_bytes.size())
         frame_bytes[idx] = v;
   endtask

   task automatic send_frame(input int len, input int flaws, input logic [15:0] ulen,
                             input bit noise);
      int pos;
      frame_bytes.delete();
      for (int i = 0; i < len; i++)
         frame_bytes.push_back(8'($urandom_range(255)));
      if (!noise) begin
         put(int'(OFF_ETYPE), ETYPE_IPV4[15:8]);
         put(OFF_ETYPE + 1, ETYPE_IPV4[7:0]);
         put(int'(OFF_PROTO), PROTO_UDP);
         for (int k = 0; k < 4; k++) begin
            put(OFF_SRC_IP + k, 8'(sip >> (8 * (3 - k))));
            put(OFF_DST_IP + k, 8'(lip >> (8 * (3 - k))));
         end
         put(int'(OFF_SPORT), spt[15:8]);
         put(OFF_SPORT + 1, spt[7:0]);
         put(int'(OFF_DPORT), lpt[15:8]);
         put(OFF_DPORT + 1, lpt[7:0]);
         put(int'(OFF_ULEN), ulen[15:8]);
         put(OFF_ULEN + 1, ulen[7:0]);
         for (int c = int'(ST_ETHERTYPE); c <= int'(ST_DPORT); c++)
            if (flaws[c]) begin
               case (uirf_status_type'(c))
                  ST_ETHERTYPE: pos = OFF_ETYPE + $urandom_range(1);
                  ST_PROTO:     pos = int'(OFF_PROTO);
                  ST_SRCIP:     pos = OFF_SRC_IP + $urandom_range(3);
                  ST_DSTIP:     pos = OFF_DST_IP + $urandom_range(3);
                  ST_SPORT:     pos = OFF_SPORT + $urandom_range(1);
                  default:      pos = OFF_DPORT + $urandom_range(1);
               endcase
               if (pos < len)
                  frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
            end
      end
      for (int i = 0; i < len; i++)
         send_word(frame_bytes[i], i == len - 1);
   endtask

   task automatic random_frame(output int len);
      int          pick, flaws, spare;
      logic [15:0] ulen;
      pick  = $urandom_range(99);
      len   = (pick < 8) ? $urandom_range(41, 1) : $urandom_range(72, int'(PAYLOAD_OFF));
      spare = (len > int'(PAYLOAD_OFF)) ? len - int'(PAYLOAD_OFF) + 6 : 6;
      ulen  = UDP_HDR + 16'($urandom_range(spare));
      pick  = $urandom_range(99);
      if (pick < 8)
         ulen = 16'($urandom_range(int'(UDP_HDR) - 1));
      else if (pick < 14)
         ulen = 16'($urandom());
      flaws = 0;
      pick  = $urandom_range(99);
      if (pick < 33)
         flaws = 1 << $urandom_range(int'(ST_DPORT), int'(ST_ETHERTYPE));
      if (pick < 8)
         flaws |= 1 << $urandom_range(int'(ST_DPORT), int'(ST_ETHERTYPE));
      send_frame(len, flaws, ulen, $urandom_range(99) < 5);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_LOCAL_IP:    lip = val;
         REG_SERVER_IP:   sip = val;
         REG_SERVER_PORT: spt = val[15:0];
         REG_LOCAL_PORT:  lpt = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int          n, len;
      bit          pressed;
      logic [31:0] a_ip, b_ip, a_port, b_port, limit;
      pressed = 1'b0;
      lip = '0;
      sip = '0;
      spt = '0;
      lpt = 16'd49152;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_frame(int'(PAYLOAD_OFF) - 1, 0, UDP_HDR, 1'b0);
      send_frame(int'(PAYLOAD_OFF), 0, UDP_HDR, 1'b0);
      send_frame(int'(PAYLOAD_OFF) + 8, 0, UDP_HDR + 16'd20, 1'b0);
      send_frame(int'(PAYLOAD_OFF) + 2, 0, UDP_HDR - 16'd1, 1'b0);
      send_frame(int'(PAYLOAD_OFF) + 4, 0, 16'hFFFF, 1'b0);

      for (int s = 0; s < SETTINGS_RUN; s++) begin
         drain();
         a_ip   = $urandom();
         b_ip   = $urandom();
         a_port = $urandom_range(16'hFFFF);
         b_port = $urandom_range(16'hFFFF);
         case (s)
            0: limit = 32'(MAX_PAYLOAD);
            1: begin
               a_ip   = '1;
               b_ip   = '1;
               a_port = 32'hFFFF;
               b_port = 32'hFFFF;
               limit  = '0;
            end
            2: limit = 32'd1;
            3: limit = $urandom_range(40, 2);
            default: begin
               a_ip   = '0;
               b_ip   = '0;
               a_port = '0;
               b_port = '0;
               limit  = {21'($urandom()), 11'h7FF};
            end
         endcase
         write_reg(REG_LOCAL_IP, a_ip);
         write_reg(REG_SERVER_IP, b_ip);
         write_reg(REG_SERVER_PORT, a_port);
         write_reg(REG_LOCAL_PORT, b_port);
         write_reg(REG_MAX_PAYLOAD, limit);
         for (int k = int'(REG_MAX_PAYLOAD) + 1; k < 2 ** $bits(csr_index); k++)
            write_reg(3'(k), $urandom());
         gaps_on = (s != 2);
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (s == 0 && n > 60 && !pressed) begin
               hold_pending = 1'b1;
               pressed      = 1'b1;
            end
            random_frame(len);
            n += len;
         end
      end

      drain();
      if (errors == 0)
         $display("udp_ipv4_receive_filter_top verification clean");
      else
         $display("udp_ipv4_receive_filter_top verification failed");
      $finish;
   end

endmodule
